### src/point_projection_depth_buffer_top_assert.svh
// Assertion macros for the point projection depth buffer.
// Used by the top level; no other dependencies.
`ifndef POINT_PROJECTION_DEPTH_BUFFER_TOP_ASSERT_SVH
`define POINT_PROJECTION_DEPTH_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPDB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define PPDB_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define PPDB_ASSERT(label, clk, rst, prop)
`define PPDB_ASSERT_RST(label, clk, prop)
`endif
`endif

### src/ppdb_pkg.sv
// Package for the point projection depth buffer: sizes, codes, types.
// No dependencies.
package ppdb_pkg;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 512;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int AddrW     = ColW + RowW;
   localparam int Cells     = MaxWidth * MaxHeight;
   localparam int EntryW    = 72;
   localparam int QuotW     = 48;

   localparam logic [2:0] ST_STORED   = 3'd0;
   localparam logic [2:0] ST_OCCLUDED = 3'd1;
   localparam logic [2:0] ST_OUTSIDE  = 3'd2;
   localparam logic [2:0] ST_BEHIND   = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;

   localparam logic [1:0] REG_FOCAL  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_NONE   = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MUL, S_DIV, S_LOOKUP, S_UPDATE, S_OUT
   } state_type;
endpackage

### src/ppdb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ppdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### src/point_projection_depth_buffer_top.sv
// Top level of the point projection depth buffer.
// Uses ppdb_pkg, ppdb_ram and point_projection_depth_buffer_top_assert.svh.
//
// Projects camera-space points (Q8.16) onto a pinhole image and keeps the
// nearest point per pixel in a 512 x 1024 entry buffer; a read beat returns
// and clears one pixel. A point beat passes from acceptance to its response
// beat through a multiply, a division (setup, 48 restoring steps for row and
// column in parallel, a range check), a memory read, a write-back and the
// output stage. A point outside the image skips the memory, a point behind
// the camera goes straight to the output stage and a read beat skips the
// multiply and division. The next beat is accepted once the response beat
// has left. After reset the buffer valid memory is cleared one entry a
// cycle, all 524288 entries, during which no beat is accepted.
`include "point_projection_depth_buffer_top_assert.svh"
module point_projection_depth_buffer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pt_x[23:0], pt_y[47:24], pt_z[71:48], read_row[80:72], read_col[90:81]
   input  logic [95:0]  req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pix_row[8:0], pix_col[18:9], near_x[42:19], near_y[66:43],
   // near_z[90:67], empty_res[91]
   output logic [95:0]  rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   localparam int AW = ppdb_pkg::AddrW;
   localparam int QW = ppdb_pkg::QuotW;

   ppdb_pkg::state_type state_ff, state_in;
   logic [15:0] focal_ff;
   logic [10:0] width_ff;
   logic [9:0]  height_ff;

   logic        kind_ff;
   logic signed [23:0] x_ff, y_ff, z_ff;
   logic [8:0]  rrow_ff;
   logic [9:0]  rcol_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [5:0]  cnt_ff, cnt_in;

   // dividends as magnitude, sign kept apart; divisor 16*z
   logic [QW-1:0] ncol_ff, nrow_ff, rcolr_ff, rrowr_ff;
   logic          scol_ff, srow_ff;
   logic [QW-1:0] qcol_ff, qrow_ff;
   logic [QW:0]   remc_ff, remr_ff;

   logic [2:0]  ost_ff;
   logic [8:0]  orow_ff;
   logic [9:0]  ocol_ff;
   logic [23:0] onx_ff, ony_ff, onz_ff;
   logic        oemp_ff, ovalid_ff;

   logic [10:0] w_sat;
   logic [9:0]  h_sat;
   assign w_sat = (width_ff > 11'(ppdb_pkg::MaxWidth)) ? 11'(ppdb_pkg::MaxWidth) : width_ff;
   assign h_sat = (height_ff > 10'(ppdb_pkg::MaxHeight)) ? 10'(ppdb_pkg::MaxHeight)
                                                        : height_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= 16'd8400;
         width_ff  <= 11'd640;
         height_ff <= 10'd480;
      end else if (csr_we) begin
         unique case (csr_index)
            ppdb_pkg::REG_FOCAL:  focal_ff  <= csr_wdata;
            ppdb_pkg::REG_WIDTH:  width_ff  <= csr_wdata[10:0];
            ppdb_pkg::REG_HEIGHT: height_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // multiply products, registered
   logic signed [40:0] px_ff, py_ff;
   logic [46:0] cw_ff, ch_ff;

   // division step
   logic [QW:0] dvs;
   logic [QW:0] trc, trr;
   assign dvs = {{(QW-26){1'b0}}, z_ff[22:0], 4'b0};
   assign trc = {remc_ff[QW-1:0], ncol_ff[QW-1]};
   assign trr = {remr_ff[QW-1:0], nrow_ff[QW-1]};

   // signed numerators
   logic signed [QW:0] numc, numr;
   assign numc = (QW+1)'(px_ff) + $signed({2'b0, cw_ff});
   assign numr = (QW+1)'(py_ff) + $signed({2'b0, ch_ff});

   // signed rounded results
   logic signed [QW:0] colv, rowv;
   assign colv = scol_ff ? -$signed({1'b0, qcol_ff}) : $signed({1'b0, qcol_ff});
   assign rowv = srow_ff ? -$signed({1'b0, qrow_ff}) : $signed({1'b0, qrow_ff});
   logic in_image;
   assign in_image = !colv[QW] && !rowv[QW] && (colv < $signed({{(QW-10){1'b0}}, w_sat}))
                     && (rowv < $signed({{(QW-9){1'b0}}, h_sat}));

   // memory
   logic          v_we, d_we;
   logic [AW-1:0] addr;
   logic          v_wd, v_rd;
   logic [ppdb_pkg::EntryW-1:0] d_wd, d_rd;
   logic [AW-1:0] pt_addr;
   assign pt_addr = {rowv[ppdb_pkg::RowW-1:0], colv[ppdb_pkg::ColW-1:0]};

   ppdb_ram #(.WIDTH(1), .DEPTH(ppdb_pkg::Cells)) u_valid (
      .clock(clock), .we(v_we), .addr(addr), .wdata(v_wd), .rdata(v_rd));
   ppdb_ram #(.WIDTH(ppdb_pkg::EntryW), .DEPTH(ppdb_pkg::Cells)) u_data (
      .clock(clock), .we(d_we), .addr(addr), .wdata(d_wd), .rdata(d_rd));

   logic rd_ok;
   assign rd_ok = 1'b1;  // read row/col widths fit the buffer exactly

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      v_we       = 1'b0;
      d_we       = 1'b0;
      v_wd       = 1'b0;
      d_wd       = {z_ff, y_ff, x_ff};
      addr       = kind_ff ? {rrow_ff, rcol_ff} : pt_addr;
      req_tready = 1'b0;
      unique case (state_ff)
         ppdb_pkg::S_CLEAR: begin
            addr = clr_ff;
            v_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ppdb_pkg::S_IDLE;
         end
         ppdb_pkg::S_IDLE: begin
            req_tready = !ovalid_ff;
            if (req_tvalid && !ovalid_ff) begin
               if (req_tuser) state_in = ppdb_pkg::S_LOOKUP;
               else if ($signed(req_tdata[71:48]) <= 24'sd0) state_in = ppdb_pkg::S_OUT;
               else state_in = ppdb_pkg::S_MUL;
            end
         end
         ppdb_pkg::S_MUL: begin
            cnt_in = 6'd0;
            state_in = ppdb_pkg::S_DIV;
         end
         ppdb_pkg::S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(QW + 1)) state_in = in_image ? ppdb_pkg::S_LOOKUP : ppdb_pkg::S_OUT;
         end
         ppdb_pkg::S_LOOKUP: state_in = ppdb_pkg::S_UPDATE;
         ppdb_pkg::S_UPDATE: begin
            if (kind_ff) begin
               v_we = rd_ok && v_rd;
            end else if (!v_rd || ($signed(d_rd[71:48]) > z_ff)) begin
               v_we = 1'b1;
               v_wd = 1'b1;
               d_we = 1'b1;
            end
            state_in = ppdb_pkg::S_OUT;
         end
         ppdb_pkg::S_OUT: state_in = ppdb_pkg::S_IDLE;
         default: state_in = ppdb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ppdb_pkg::S_CLEAR;
         clr_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == ppdb_pkg::S_OUT) ovalid_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      unique case (state_ff)
         ppdb_pkg::S_IDLE: begin
            if (req_tvalid && !ovalid_ff) begin
               kind_ff <= req_tuser;
               x_ff    <= req_tdata[23:0];
               y_ff    <= req_tdata[47:24];
               z_ff    <= req_tdata[71:48];
               rrow_ff <= req_tdata[80:72];
               rcol_ff <= req_tdata[90:81];
               ost_ff  <= req_tuser ? ppdb_pkg::ST_READ : ppdb_pkg::ST_BEHIND;
               orow_ff <= req_tuser ? req_tdata[80:72] : 9'd0;
               ocol_ff <= req_tuser ? req_tdata[90:81] : 10'd0;
               onx_ff  <= '0;
               ony_ff  <= '0;
               onz_ff  <= '0;
               oemp_ff <= 1'b0;
            end
         end
         ppdb_pkg::S_MUL: begin
            px_ff <= $signed({1'b0, focal_ff}) * x_ff;
            py_ff <= $signed({1'b0, focal_ff}) * y_ff;
            cw_ff <= 47'({w_sat, 3'b0}) * 47'(z_ff[22:0]);
            ch_ff <= 47'({h_sat, 3'b0}) * 47'(z_ff[22:0]);
         end
         ppdb_pkg::S_DIV: begin
            if (cnt_ff == 6'd0) begin
               // magnitude plus half the divisor (8*z) for round half away
               scol_ff <= numc[QW];
               srow_ff <= numr[QW];
               ncol_ff <= QW'(numc[QW] ? -numc : numc) + QW'({z_ff[22:0], 3'b0});
               nrow_ff <= QW'(numr[QW] ? -numr : numr) + QW'({z_ff[22:0], 3'b0});
               remc_ff <= '0;
               remr_ff <= '0;
            end else if (cnt_ff <= 6'(QW)) begin
               ncol_ff <= {ncol_ff[QW-2:0], 1'b0};
               nrow_ff <= {nrow_ff[QW-2:0], 1'b0};
               remc_ff <= (trc >= dvs) ? trc - dvs : trc;
               remr_ff <= (trr >= dvs) ? trr - dvs : trr;
               qcol_ff <= {qcol_ff[QW-2:0], trc >= dvs};
               qrow_ff <= {qrow_ff[QW-2:0], trr >= dvs};
            end else begin
               ost_ff <= ppdb_pkg::ST_OUTSIDE;
            end
         end
         ppdb_pkg::S_LOOKUP: if (!kind_ff) begin
            orow_ff <= rowv[8:0];
            ocol_ff <= colv[9:0];
         end
         ppdb_pkg::S_UPDATE: begin
            if (kind_ff) begin
               oemp_ff <= !v_rd;
               onx_ff  <= v_rd ? d_rd[23:0]  : 24'd0;
               ony_ff  <= v_rd ? d_rd[47:24] : 24'd0;
               onz_ff  <= v_rd ? d_rd[71:48] : 24'd0;
            end else if (!v_rd || ($signed(d_rd[71:48]) > z_ff)) begin
               ost_ff <= ppdb_pkg::ST_STORED;
            end else begin
               ost_ff <= ppdb_pkg::ST_OCCLUDED;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = ost_ff;
   assign rsp_tdata  = {4'b0, oemp_ff, onz_ff, ony_ff, onx_ff, ocol_ff, orow_ff};

   `PPDB_ASSERT(a_no_accept_busy, clock, reset, (req_tvalid && req_tready) |-> !rsp_tvalid)
   `PPDB_ASSERT(a_hold_out, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
   `PPDB_ASSERT(a_write_one, clock, reset, d_we |-> (v_we && v_wd))
   `PPDB_ASSERT_RST(a_clear_ready, clock, (state_ff == ppdb_pkg::S_CLEAR) |-> !req_tready)
endmodule
